// ===== src/gmuc_pkg.sv =====
`default_nettype none

package gmuc_pkg;

   // fixed field widths
   localparam int WALL_W   = 9;
   localparam int GROUPS_W = 9;
   localparam int SIZE_REG_W = 5;

   // stream widths (fields packed from bit 0, padded to whole bytes)
   localparam int REQ_TDATA_W = 16;   // wall_index
   localparam int RSP_TDATA_W = 24;   // wall_removed, index_error, wall_echo, groups_left

   // config port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register indexes (byte address = 4 * index)
   typedef enum logic {
      REG_GRID_WIDTH  = 1'b0,
      REG_GRID_LENGTH = 1'b1
   } reg_index_type;

   // request kinds
   typedef enum logic {
      REQ_CLEAR = 1'b0,
      REQ_WALL  = 1'b1
   } req_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_DIV,
      ST_MAP,
      ST_RDP,
      ST_RDN,
      ST_GN,
      ST_SZP,
      ST_SZN,
      ST_PICK,
      ST_SCAN,
      ST_DRAIN,
      ST_WRK,
      ST_WRD,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

// ===== src/gmuc_divider.sv =====
`default_nettype none

// restoring divider, one quotient bit per cycle
module gmuc_divider #(
   parameter int DIVISOR_W = 5
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [gmuc_pkg::WALL_W-1:0]   dividend,
   input  wire logic [DIVISOR_W-1:0]          divisor,
   output logic                               done,
   output logic [gmuc_pkg::WALL_W-1:0]        quotient,
   output logic [DIVISOR_W-1:0]               remainder
);

   localparam int STEP_W = $clog2(gmuc_pkg::WALL_W + 1);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [STEP_W-1:0]           step_ff, step_in;
   logic [gmuc_pkg::WALL_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]        rem_ff, rem_in;
   logic [DIVISOR_W-1:0]        dsr_ff, dsr_in;
   logic [DIVISOR_W:0]          trial;
   logic [DIVISOR_W:0]          diff;
   logic                        fits;

   assign trial = {rem_ff, quo_ff[gmuc_pkg::WALL_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[gmuc_pkg::WALL_W-2:0], fits};
         rem_in  = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(gmuc_pkg::WALL_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ===== src/gmuc_csr.sv =====
`default_nettype none

// size registers and derived grid geometry (registered outputs)
module gmuc_csr #(
   parameter int MAX_WIDTH  = 16,
   parameter int MAX_LENGTH = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [gmuc_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [gmuc_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [gmuc_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                 pready,
   output logic                                 cfg_write,
   output logic [$clog2(MAX_WIDTH+1)-1:0]       eff_w,
   output logic [$clog2(MAX_LENGTH+1)-1:0]      eff_l,
   output logic [$clog2(MAX_WIDTH*MAX_LENGTH+1)-1:0]   cells,
   output logic [$clog2(MAX_WIDTH*MAX_LENGTH)-1:0]     last_cell,
   output logic [$clog2(2*MAX_WIDTH*MAX_LENGTH+1)-1:0] hwalls,
   output logic [$clog2(2*MAX_WIDTH*MAX_LENGTH+1)-1:0] total
);

   localparam int MAX_CELLS = MAX_WIDTH * MAX_LENGTH;
   localparam int WW   = $clog2(MAX_WIDTH + 1);
   localparam int LW   = $clog2(MAX_LENGTH + 1);
   localparam int CNTW = $clog2(MAX_CELLS + 1);
   localparam int CAW  = $clog2(MAX_CELLS);
   localparam int TW   = $clog2(2 * MAX_CELLS + 1);
   localparam int RW   = gmuc_pkg::SIZE_REG_W;

   logic [RW-1:0]   width_ff, width_in;
   logic [RW-1:0]   length_ff, length_in;
   logic [WW-1:0]   eff_w_ff, eff_w_in;
   logic [LW-1:0]   eff_l_ff, eff_l_in;
   logic [CNTW-1:0] cells_ff;
   logic [CAW-1:0]  last_cell_ff;
   logic [TW-1:0]   hwalls_ff;
   logic [TW-1:0]   total_ff;
   logic            wr;
   gmuc_pkg::reg_index_type sel;

   assign sel = gmuc_pkg::reg_index_type'(paddr[2]);
   assign wr  = psel && penable && pwrite;

   always_comb begin
      width_in  = width_ff;
      length_in = length_ff;
      if (wr) begin
         unique case (sel)
            gmuc_pkg::REG_GRID_WIDTH:  width_in  = pwdata[RW-1:0];
            gmuc_pkg::REG_GRID_LENGTH: length_in = pwdata[RW-1:0];
            default: ;
         endcase
      end
   end

   // zero acts as one, oversize acts as the maximum
   always_comb begin
      if (width_ff == '0)
         eff_w_in = WW'(1);
      else if (32'(width_ff) > MAX_WIDTH)
         eff_w_in = WW'(MAX_WIDTH);
      else
         eff_w_in = WW'(width_ff);
      if (length_ff == '0)
         eff_l_in = LW'(1);
      else if (32'(length_ff) > MAX_LENGTH)
         eff_l_in = LW'(MAX_LENGTH);
      else
         eff_l_in = LW'(length_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RW'(16);
         length_ff <= RW'(16);
      end else begin
         width_ff  <= width_in;
         length_ff <= length_in;
      end
      eff_w_ff     <= eff_w_in;
      eff_l_ff     <= eff_l_in;
      cells_ff     <= CNTW'(eff_w_ff) * CNTW'(eff_l_ff);
      hwalls_ff    <= TW'(eff_l_ff - LW'(1)) * TW'(eff_w_ff);
      total_ff     <= TW'({cells_ff, 1'b0} - eff_w_ff - eff_l_ff);
      last_cell_ff <= CAW'(cells_ff - CNTW'(1));
   end

   always_comb begin
      unique case (sel)
         gmuc_pkg::REG_GRID_WIDTH:  prdata = 32'(width_ff);
         gmuc_pkg::REG_GRID_LENGTH: prdata = 32'(length_ff);
         default:                   prdata = '0;
      endcase
   end

   assign pready    = 1'b1;
   assign cfg_write = wr;
   assign eff_w     = eff_w_ff;
   assign eff_l     = eff_l_ff;
   assign cells     = cells_ff;
   assign last_cell = last_cell_ff;
   assign hwalls    = hwalls_ff;
   assign total     = total_ff;

endmodule

`default_nettype wire

// ===== src/grid_maze_union_carver.sv =====
`default_nettype none

// A clear request clears one table row per cycle over all MAX_WIDTH*MAX_LENGTH rows;
//   an out-of-range wall goes straight to the result; joined groups in one end after the size read;
//   a merge ends with a relabel scan (one cell group id per cycle over all W*L cells) and size writes.
// Throughput: one beat at a time, the next beat is taken once the result is registered.
// Reset (synchronous, active high) and every size register write start the clearing pass over
//   all MAX_WIDTH*MAX_LENGTH table rows; no request beat is taken until it ends.
module grid_maze_union_carver #(
   parameter int MAX_WIDTH  = 16,
   parameter int MAX_LENGTH = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request stream
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [gmuc_pkg::REQ_TDATA_W-1:0] req_tdata,  // [8:0] wall_index
   input  wire logic [0:0]                       req_tuser,  // [0] req_type
   // result stream
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // [0] wall_removed, [1] index_error, [10:2] wall_echo, [19:11] groups_left
   output logic      [gmuc_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // size registers
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [gmuc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [gmuc_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [gmuc_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                  csr_pready
);

   localparam int MAX_CELLS = MAX_WIDTH * MAX_LENGTH;
   localparam int WW   = $clog2(MAX_WIDTH + 1);
   localparam int LW   = $clog2(MAX_LENGTH + 1);
   localparam int DVW  = (WW > LW) ? WW : LW;
   localparam int CNTW = $clog2(MAX_CELLS + 1);   // sizes and counts
   localparam int CAW  = $clog2(MAX_CELLS);       // cell address and group id
   localparam int TW   = $clog2(2 * MAX_CELLS + 1);
   localparam int XW   = gmuc_pkg::WALL_W;
   localparam int CMPW = (TW > XW) ? TW : XW;
   localparam int CRDW = XW + 1;                  // decoded coordinate
   localparam int PW   = CRDW + WW + 1;           // y*W + x before trimming

   // ------------------------------------------------------------------
   // size registers and geometry
   // ------------------------------------------------------------------
   logic            cfg_write;
   logic [WW-1:0]   eff_w;
   logic [LW-1:0]   eff_l;
   logic [CNTW-1:0] cells;
   logic [CAW-1:0]  last_cell;
   logic [TW-1:0]   hwalls;
   logic [TW-1:0]   total;

   gmuc_csr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_LENGTH (MAX_LENGTH)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (csr_psel),
      .penable   (csr_penable),
      .pwrite    (csr_pwrite),
      .paddr     (csr_paddr),
      .pwdata    (csr_pwdata),
      .prdata    (csr_prdata),
      .pready    (csr_pready),
      .cfg_write (cfg_write),
      .eff_w     (eff_w),
      .eff_l     (eff_l),
      .cells     (cells),
      .last_cell (last_cell),
      .hwalls    (hwalls),
      .total     (total)
   );

   // ------------------------------------------------------------------
   // request decode at the accepting edge
   // ------------------------------------------------------------------
   gmuc_pkg::state_type state_ff, state_in;

   logic          req_beat;
   logic [XW-1:0] wall_in;
   logic          is_wall;
   logic          idx_bad;
   logic          horiz_in;
   logic [XW-1:0] dividend;
   logic [DVW-1:0] divisor;
   logic          div_start;
   logic          div_done;
   logic [XW-1:0] div_q;
   logic [DVW-1:0] div_r;

   assign req_beat = req_tvalid && req_tready;
   assign wall_in  = req_tdata[XW-1:0];
   assign is_wall  = gmuc_pkg::req_kind_type'(req_tuser[0]) == gmuc_pkg::REQ_WALL;
   assign idx_bad  = CMPW'(wall_in) >= CMPW'(total);
   assign horiz_in = CMPW'(wall_in) < CMPW'(hwalls);
   // horizontal: wall / W gives row-1 and column; vertical: (wall - H) / L gives column-1, row
   assign dividend = horiz_in ? wall_in : XW'(CMPW'(wall_in) - CMPW'(hwalls));
   assign divisor  = horiz_in ? DVW'(eff_w) : DVW'(eff_l);
   assign div_start = req_beat && is_wall && !idx_bad;

   // the shared divider: quotient and remainder, one bit per cycle
   gmuc_divider #(
      .DIVISOR_W (DVW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (dividend),
      .divisor   (divisor),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   // ------------------------------------------------------------------
   // working registers
   // ------------------------------------------------------------------
   logic [XW-1:0]   widx_ff;
   logic            horiz_ff;
   logic            err_ff;
   logic            removed_ff;
   logic            reply_ff;       // clearing pass answers a request
   logic [CAW-1:0]  cnt_ff;         // clear row / scan read address
   logic [CAW-1:0]  par_ff;
   logic [CAW-1:0]  nb_ff;
   logic [CAW-1:0]  gp_ff;
   logic [CAW-1:0]  gn_ff;
   logic [CNTW-1:0] szp_ff;
   logic [CAW-1:0]  keep_ff;
   logic [CAW-1:0]  drop_ff;
   logic [CNTW-1:0] sum_ff;
   logic [CNTW-1:0] group_count_ff;
   logic            scan_vld_ff;
   logic [CAW-1:0]  scan_addr_ff;
   logic            rsp_valid_ff;
   logic [gmuc_pkg::RSP_TDATA_W-1:0] rsp_data_ff;

   // tables
   logic [CAW-1:0]  cg_mem [MAX_CELLS];    // group id per cell
   logic [CNTW-1:0] sz_mem [MAX_CELLS];    // size per group id
   logic [1:0]      wall_mem [MAX_CELLS];  // wall-present bits, two walls a row
   logic [CAW-1:0]  cg_rdata_ff;
   logic [CNTW-1:0] sz_rdata_ff;

   logic [CAW-1:0]  cg_raddr;
   logic [CAW-1:0]  sz_raddr;
   logic            scan_hit;
   logic            clear_last;
   logic            rsp_free;
   logic [CRDW-1:0] xcoord;
   logic [CRDW-1:0] ycoord;
   logic [PW-1:0]   par_full;
   logic [CAW-1:0]  wall_row;

   assign clear_last = cnt_ff == CAW'(MAX_CELLS - 1);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign scan_hit   = scan_vld_ff && (cg_rdata_ff == drop_ff);
   assign wall_row   = CAW'(widx_ff >> 1);

   // horizontal wall: y = q + 1, x = r; vertical wall: x = q + 1, y = r
   assign xcoord   = horiz_ff ? CRDW'(div_r) : CRDW'(div_q) + CRDW'(1);
   assign ycoord   = horiz_ff ? CRDW'(div_q) + CRDW'(1) : CRDW'(div_r);
   assign par_full = PW'(ycoord * eff_w) + PW'(xcoord);

   // ------------------------------------------------------------------
   // sequencer: next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gmuc_pkg::ST_IDLE: begin
            if (req_beat) begin
               if (!is_wall)
                  state_in = gmuc_pkg::ST_CLEAR;
               else if (idx_bad)
                  state_in = gmuc_pkg::ST_FINISH;
               else
                  state_in = gmuc_pkg::ST_DIV;
            end
         end
         gmuc_pkg::ST_CLEAR: begin
            if (clear_last)
               state_in = reply_ff ? gmuc_pkg::ST_FINISH : gmuc_pkg::ST_IDLE;
         end
         gmuc_pkg::ST_DIV: begin
            if (div_done)
               state_in = gmuc_pkg::ST_MAP;
         end
         gmuc_pkg::ST_MAP:  state_in = gmuc_pkg::ST_RDP;
         gmuc_pkg::ST_RDP:  state_in = gmuc_pkg::ST_RDN;
         gmuc_pkg::ST_RDN:  state_in = gmuc_pkg::ST_GN;
         gmuc_pkg::ST_GN:   state_in = gmuc_pkg::ST_SZP;
         gmuc_pkg::ST_SZP: begin
            state_in = (gp_ff == gn_ff) ? gmuc_pkg::ST_FINISH : gmuc_pkg::ST_SZN;
         end
         gmuc_pkg::ST_SZN:  state_in = gmuc_pkg::ST_PICK;
         gmuc_pkg::ST_PICK: state_in = gmuc_pkg::ST_SCAN;
         gmuc_pkg::ST_SCAN: begin
            if (cnt_ff == last_cell)
               state_in = gmuc_pkg::ST_DRAIN;
         end
         gmuc_pkg::ST_DRAIN: state_in = gmuc_pkg::ST_WRK;
         gmuc_pkg::ST_WRK:   state_in = gmuc_pkg::ST_WRD;
         gmuc_pkg::ST_WRD:   state_in = gmuc_pkg::ST_FINISH;
         gmuc_pkg::ST_FINISH: begin
            if (rsp_free)
               state_in = gmuc_pkg::ST_IDLE;
         end
         default: state_in = gmuc_pkg::ST_IDLE;
      endcase
      // a size write restarts the clearing pass
      if (cfg_write)
         state_in = gmuc_pkg::ST_CLEAR;
   end

   // ------------------------------------------------------------------
   // sequencer: outputs
   // ------------------------------------------------------------------
   always_comb begin
      req_tready = 1'b0;
      cg_raddr   = '0;
      sz_raddr   = '0;
      unique case (state_ff)
         gmuc_pkg::ST_IDLE: req_tready = 1'b1;
         gmuc_pkg::ST_RDP:  cg_raddr   = par_ff;
         gmuc_pkg::ST_RDN:  cg_raddr   = nb_ff;
         gmuc_pkg::ST_SCAN: cg_raddr   = cnt_ff;
         gmuc_pkg::ST_SZP:  sz_raddr   = gp_ff;
         gmuc_pkg::ST_SZN:  sz_raddr   = gn_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= gmuc_pkg::ST_CLEAR;
      else
         state_ff <= state_in;
   end

   // ------------------------------------------------------------------
   // control registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         reply_ff     <= 1'b0;
         scan_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         scan_vld_ff <= state_ff == gmuc_pkg::ST_SCAN;
         if (cfg_write) begin
            cnt_ff   <= '0;
            reply_ff <= 1'b0;
         end else if (state_ff == gmuc_pkg::ST_IDLE) begin
            cnt_ff   <= '0;
            reply_ff <= 1'b1;
         end else if (state_ff == gmuc_pkg::ST_CLEAR
                      || state_ff == gmuc_pkg::ST_SCAN) begin
            cnt_ff <= cnt_ff + CAW'(1);
         end else if (state_ff == gmuc_pkg::ST_PICK) begin
            cnt_ff <= '0;
         end
         if (state_ff == gmuc_pkg::ST_FINISH && rsp_free)
            rsp_valid_ff <= 1'b1;
         else if (rsp_tready)
            rsp_valid_ff <= 1'b0;
      end
   end

   function automatic logic [gmuc_pkg::GROUPS_W-1:0] GROUPS_W_MASK(input logic [CNTW-1:0] v);
      GROUPS_W_MASK = gmuc_pkg::GROUPS_W'(v);
   endfunction

   // ------------------------------------------------------------------
   // datapath registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      unique case (state_ff)
         gmuc_pkg::ST_IDLE: begin
            widx_ff    <= wall_in;
            horiz_ff   <= horiz_in;
            err_ff     <= is_wall && idx_bad;
            removed_ff <= 1'b0;
         end
         gmuc_pkg::ST_CLEAR: begin
            if (clear_last)
               group_count_ff <= cells;
         end
         gmuc_pkg::ST_MAP: par_ff <= CAW'(par_full);
         gmuc_pkg::ST_RDP: begin
            // neighbor sits one row up or one column left
            nb_ff <= par_ff - (horiz_ff ? CAW'(eff_w) : CAW'(1));
         end
         gmuc_pkg::ST_RDN: gp_ff  <= cg_rdata_ff;
         gmuc_pkg::ST_GN:  gn_ff  <= cg_rdata_ff;
         gmuc_pkg::ST_SZN: szp_ff <= sz_rdata_ff;
         gmuc_pkg::ST_PICK: begin
            // strictly larger neighbor group survives; a tie keeps the parent's id
            if (sz_rdata_ff > szp_ff) begin
               keep_ff <= gn_ff;
               drop_ff <= gp_ff;
            end else begin
               keep_ff <= gp_ff;
               drop_ff <= gn_ff;
            end
            sum_ff <= sz_rdata_ff + szp_ff;
         end
         gmuc_pkg::ST_WRD: begin
            removed_ff <= 1'b1;
            if (group_count_ff != '0)
               group_count_ff <= group_count_ff - CNTW'(1);
         end
         gmuc_pkg::ST_FINISH: begin
            if (rsp_free)
               rsp_data_ff <= gmuc_pkg::RSP_TDATA_W'({GROUPS_W_MASK(group_count_ff),
                                                      widx_ff, err_ff, removed_ff});
         end
         default: ;
      endcase
      scan_addr_ff <= cnt_ff;
   end

   // ------------------------------------------------------------------
   // tables: one write each; the group and size tables also have one registered read each
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (state_ff == gmuc_pkg::ST_CLEAR)
         cg_mem[cnt_ff] <= cnt_ff;
      else if (scan_hit)
         cg_mem[scan_addr_ff] <= keep_ff;
      cg_rdata_ff <= cg_mem[cg_raddr];
   end

   always_ff @(posedge clock) begin
      if (state_ff == gmuc_pkg::ST_CLEAR)
         sz_mem[cnt_ff] <= CNTW'(1);
      else if (state_ff == gmuc_pkg::ST_WRK)
         sz_mem[keep_ff] <= sum_ff;
      else if (state_ff == gmuc_pkg::ST_WRD)
         sz_mem[drop_ff] <= '0;
      sz_rdata_ff <= sz_mem[sz_raddr];
   end

   always_ff @(posedge clock) begin
      if (state_ff == gmuc_pkg::ST_CLEAR)
         wall_mem[cnt_ff] <= 2'b11;
      else if (state_ff == gmuc_pkg::ST_PICK)
         wall_mem[wall_row][widx_ff[0]] <= 1'b0;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------
   a_no_self_merge: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gmuc_pkg::ST_SCAN) |-> (keep_ff != drop_ff))
      else $error("relabel scan with equal keep and drop groups");

   a_count_drops: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gmuc_pkg::ST_WRD && group_count_ff != '0 && !cfg_write)
      |=> (group_count_ff == $past(group_count_ff) - CNTW'(1)))
      else $error("group count did not drop after a merge");

   a_div_in_step: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == gmuc_pkg::ST_DIV))
      else $error("divider finished outside the decode step");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gmuc_pkg::ST_IDLE) |-> (group_count_ff <= cells))
      else $error("group count above cell count");

   a_err_not_removed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff[0] && rsp_data_ff[1]))
      else $error("result flags both error and removal");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_W = 16;
   localparam int MAX_L = 16;
   localparam int MAX_CELLS = MAX_W * MAX_L;
   localparam int MAX_WALLS = 2 * MAX_CELLS;
   localparam int DRAIN_CYCLES = 300;   // longer than a full relabel scan or clear pass
   localparam int ITEM_TARGET = 650;

   // one request beat and one result beat, as the block sees them
   typedef struct packed {
      gmuc_pkg::req_kind_type kind;
      logic [8:0]             widx;
   } carve_req_type;

   typedef struct packed {
      logic       removed;
      logic       err;
      logic [8:0] echo;
      logic [8:0] groups;
   } carve_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [gmuc_pkg::REQ_TDATA_W-1:0] req_tdata = '0;   // [8:0] wall_index
   logic [0:0]                       req_tuser = '0;   // [0] req_type
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   // [0] wall_removed, [1] index_error, [10:2] wall_echo, [19:11] groups_left
   logic [gmuc_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                             csr_psel = 1'b0;
   logic                             csr_penable = 1'b0;
   logic                             csr_pwrite = 1'b0;
   logic [gmuc_pkg::CSR_ADDR_W-1:0]  csr_paddr = '0;
   logic [gmuc_pkg::CSR_DATA_W-1:0]  csr_pwdata = '0;
   logic [gmuc_pkg::CSR_DATA_W-1:0]  csr_prdata;
   logic                             csr_pready;

   grid_maze_union_carver #(
      .MAX_WIDTH  (MAX_W),
      .MAX_LENGTH (MAX_L)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 0;
   end

   // ---------------------------------------------------------------
   // Maze predictor: own copy of the size registers and the union tables
   // ---------------------------------------------------------------
   logic [4:0] cfg_width;
   logic [4:0] cfg_length;
   int         cell_grp [MAX_CELLS];
   int         grp_size [MAX_CELLS];
   bit         wall_up  [MAX_WALLS];
   int         groups_now;

   function automatic int eff_size(logic [4:0] raw, int max_size);
      if (raw < 1) return 1;
      if (raw > max_size) return max_size;
      return raw;
   endfunction

   // every cell its own group, every wall standing
   function automatic void clear_maze();
      for (int c = 0; c < MAX_CELLS; c++) begin
         cell_grp[c] = c;
         grp_size[c] = 1;
      end
      for (int w = 0; w < MAX_WALLS; w++) wall_up[w] = 1'b1;
      groups_now = eff_size(cfg_width, MAX_W) * eff_size(cfg_length, MAX_L);
   endfunction

   function automatic carve_result_type carve_step(carve_req_type rq);
      int w, l, cells, hwalls, total, idx, v, par, nb, gp, gn, keep, drop;
      carve_result_type res;
      w      = eff_size(cfg_width, MAX_W);
      l      = eff_size(cfg_length, MAX_L);
      cells  = w * l;
      hwalls = (l - 1) * w;
      total  = 2 * cells - w - l;
      idx    = int'(rq.widx);
      res.removed = 1'b0;
      res.err     = 1'b0;
      res.echo    = rq.widx;
      if (rq.kind == gmuc_pkg::REQ_CLEAR) begin
         clear_maze();
      end else if (idx >= total) begin
         res.err = 1'b1;
      end else begin
         // horizontal walls first, then vertical ones column by column
         if (idx < hwalls) begin
            par = (idx / w + 1) * w + idx % w;
            nb  = par - w;
         end else begin
            v   = idx - hwalls;
            par = (v % l) * w + v / l + 1;
            nb  = par - 1;
         end
         gp = cell_grp[par];
         gn = cell_grp[nb];
         if (gp != gn) begin
            // larger group survives, tie goes to the parent's group
            keep = gp;
            drop = gn;
            if (grp_size[gn] > grp_size[gp]) begin
               keep = gn;
               drop = gp;
            end
            wall_up[idx] = 1'b0;
            for (int c = 0; c < cells; c++)
               if (cell_grp[c] == drop) cell_grp[c] = keep;
            grp_size[keep] += grp_size[drop];
            grp_size[drop] = 0;
            if (groups_now > 0) groups_now--;
            res.removed = 1'b1;
         end
      end
      res.groups = groups_now[8:0];
      return res;
   endfunction

   // ---------------------------------------------------------------
   // Bookkeeping
   // ---------------------------------------------------------------
   carve_req_type    pending_reqs[$];
   carve_result_type expected_results[$];
   carve_req_type    on_bus;
   int               items_pushed = 0;
   int               rsp_count = 0;
   int               errors = 0;
   int               holdoff_left = 0;
   bit               holdoff_done = 1'b0;

   task automatic flag(string what);
      errors++;
      if (errors <= 10) $display("%0t: mismatch: %s", $realtime, what);
   endtask

   task automatic check_field(string name, logic [8:0] want, logic [8:0] got, int widx);
      if (got !== want)
         flag($sformatf("wall %0d %s expected %0d got %0d", widx, name, want, got));
   endtask

   // random idling, off during one quiet stretch of beats
   function automatic bit idle_now();
      if (rsp_count >= 300 && rsp_count < 420) return 1'b0;
      return $urandom_range(99) < 7;
   endfunction

   // ---------------------------------------------------------------
   // Request driver: presents the next pending beat, predicts on accept
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      carve_result_type predicted;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predicted        = carve_step(on_bus);
            expected_results = {expected_results, predicted};
         end
         if (!req_tvalid || req_tready) begin
            if (pending_reqs.size() != 0 && !idle_now()) begin
               on_bus = pending_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {{(gmuc_pkg::REQ_TDATA_W - 9){1'b0}}, on_bus.widx};
               req_tuser  <= on_bus.kind;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Result monitor: checks each beat against the oldest expectation
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      carve_result_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.removed = rsp_tdata[0];
            got.err     = rsp_tdata[1];
            got.echo    = rsp_tdata[10:2];
            got.groups  = rsp_tdata[19:11];
            rsp_count++;
            if (expected_results.size() == 0) begin
               flag($sformatf("result beat for wall %0d with nothing expected", got.echo));
            end else begin
               want = expected_results.pop_front();
               check_field("wall_removed", 9'(want.removed), 9'(got.removed), want.echo);
               check_field("index_error", 9'(want.err), 9'(got.err), want.echo);
               check_field("wall_echo", want.echo, got.echo, want.echo);
               check_field("groups_left", want.groups, got.groups, want.echo);
            end
         end
         // one long hold-off while the sender still has beats queued, so the
         // block backs up and drops req_tready
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_tready <= 1'b0;
         end else if (!holdoff_done && rsp_count >= 100 && pending_reqs.size() > 8) begin
            holdoff_done = 1'b1;
            holdoff_left = 600;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !idle_now();
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   task automatic push_req(gmuc_pkg::req_kind_type kind, int widx);
      carve_req_type rq;
      rq.kind = kind;
      rq.widx = widx[8:0];
      pending_reqs = {pending_reqs, rq};
      items_pushed++;
   endtask

   // sender pause: nothing queued, nothing on the bus, nothing outstanding
   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(posedge clock);
   endtask

   // size register write, then read back; the write also clears the maze
   task automatic csr_write(gmuc_pkg::reg_index_type idx, logic [4:0] value);
      logic [gmuc_pkg::CSR_DATA_W-1:0] rd;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {{(gmuc_pkg::CSR_DATA_W - 5){1'b0}}, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx == gmuc_pkg::REG_GRID_WIDTH) cfg_width = value;
      else cfg_length = value;
      clear_maze();
      @(posedge clock);
      csr_psel <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rd = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (rd !== {{(gmuc_pkg::CSR_DATA_W - 5){1'b0}}, value})
         flag($sformatf("register %s read expected %0d got %0h", idx.name(), value, rd));
   endtask

   // one grid size: a shuffled visit order of its walls, with repeats,
   // stray indexes and the odd clear mixed in
   task automatic run_phase(int w_raw, int l_raw);
      int w, l, total, n, j, k, tmp, r;
      int order[$];
      wait_drained();
      csr_write(gmuc_pkg::REG_GRID_WIDTH, w_raw[4:0]);
      csr_write(gmuc_pkg::REG_GRID_LENGTH, l_raw[4:0]);
      w     = eff_size(w_raw[4:0], MAX_W);
      l     = eff_size(l_raw[4:0], MAX_L);
      total = 2 * w * l - w - l;
      n     = total + total / 4 + 4;
      if (n > 100) n = 100;
      for (int i = 0; i < total; i++) order = {order, i};
      for (int i = total - 1; i > 0; i--) begin
         k        = $urandom_range(i);
         tmp      = order[i];
         order[i] = order[k];
         order[k] = tmp;
      end
      j = 0;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 4) push_req(gmuc_pkg::REQ_CLEAR, $urandom_range(511));
         else if (r < 10) push_req(gmuc_pkg::REQ_WALL, $urandom_range(511));
         else if (r < 14 && j > 0) push_req(gmuc_pkg::REQ_WALL, order[$urandom_range(j - 1)]);
         else if (j < total) push_req(gmuc_pkg::REQ_WALL, order[j++]);
         else push_req(gmuc_pkg::REQ_WALL, $urandom_range(511));
      end
   endtask

   initial begin
      int w_raw, l_raw;
      cfg_width  = 5'd16;
      cfg_length = 5'd16;
      clear_maze();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed part on the full 16 x 16 grid
      csr_write(gmuc_pkg::REG_GRID_WIDTH, 5'd16);
      csr_write(gmuc_pkg::REG_GRID_LENGTH, 5'd16);
      push_req(gmuc_pkg::REQ_CLEAR, 0);
      push_req(gmuc_pkg::REQ_WALL, 0);      // tie, parent's group survives
      push_req(gmuc_pkg::REQ_WALL, 0);      // already open
      push_req(gmuc_pkg::REQ_WALL, 240);    // first vertical, neighbour's group is larger
      push_req(gmuc_pkg::REQ_WALL, 16);
      push_req(gmuc_pkg::REQ_WALL, 239);    // last horizontal
      push_req(gmuc_pkg::REQ_WALL, 479);    // last wall
      push_req(gmuc_pkg::REQ_WALL, 480);    // first index out of range
      push_req(gmuc_pkg::REQ_WALL, 511);
      push_req(gmuc_pkg::REQ_WALL, 255);
      push_req(gmuc_pkg::REQ_CLEAR, 511);   // clear still echoes the index
      push_req(gmuc_pkg::REQ_WALL, 0);      // opens again after the clear
      push_req(gmuc_pkg::REQ_WALL, 256);

      // size extremes, including the clamped register values
      run_phase(1, 1);
      run_phase(0, 0);
      run_phase(2, 2);
      run_phase(1, 16);
      run_phase(16, 1);
      run_phase(31, 31);
      run_phase(17, 3);

      // random grids, mostly small
      while (items_pushed < ITEM_TARGET) begin
         w_raw = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(2, 8);
         l_raw = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(2, 8);
         run_phase(w_raw, l_raw);
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #8_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire
